@@ src/mme_pkg.sv @@
// Shared types, constants and helpers for the matrix multiply engine.
// No dependencies; every other file of the block imports this package.
package mme_pkg;

    // Store geometry and element format
    localparam int MAX_DIM    = 8;
    localparam int DATA_WIDTH = 16;
    localparam int DEPTH      = MAX_DIM * MAX_DIM;
    localparam int DIM_W      = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
    localparam int IDX_W      = 6;
    localparam int PROD_W     = 2 * DATA_WIDTH;
    localparam int RES_W      = 40;

    // Configuration register format
    localparam int CFG_W      = 4;
    localparam int ADDR_W     = 4;
    localparam int PDATA_W    = 32;
    localparam logic [CFG_W-1:0] CFG_DIM_RESET = CFG_W'(MAX_DIM);

    // Register indexes (byte address divided by four)
    localparam logic [1:0] REG_ROWS      = 2'd0;
    localparam logic [1:0] REG_INNER     = 2'd1;
    localparam logic [1:0] REG_COLS      = 2'd2;
    localparam logic [1:0] REG_TRANSPOSE = 2'd3;

    // Request op codes
    localparam logic [1:0] OP_LOAD_A  = 2'd0;
    localparam logic [1:0] OP_LOAD_B  = 2'd1;
    localparam logic [1:0] OP_COMPUTE = 2'd2;

    // Configuration as seen by the controller
    typedef struct packed {
        logic [CFG_W-1:0] rows;
        logic [CFG_W-1:0] inner;
        logic [CFG_W-1:0] cols;
        logic             transpose;
    } t_cfg;

    // Store write command
    typedef struct packed {
        logic                  we_a;
        logic                  we_b;
        logic [IDX_W-1:0]      addr;
        logic [DATA_WIDTH-1:0] data;
    } t_wr_cmd;

    // Tag that travels with each multiply-accumulate step
    typedef struct packed {
        logic             first;
        logic             last_k;
        logic             last_elem;
        logic [DIM_W-1:0] row;
        logic [DIM_W-1:0] col;
    } t_tag;

    // Per-cycle compute command
    typedef struct packed {
        logic             rd;
        logic [IDX_W-1:0] a_addr;
        logic [IDX_W-1:0] b_addr;
        t_tag             tag;
    } t_mac_cmd;

    // Datapath status back to the controller
    typedef struct packed {
        logic done;
    } t_dp_status;

    // Saturate a dimension to 1..MAX_DIM and return it minus one
    function automatic logic [DIM_W-1:0] dim_limit(input logic [CFG_W-1:0] d);
        logic [CFG_W-1:0] t;
        begin
            if (d == '0) begin
                t = '0;
            end else if (d > CFG_W'(MAX_DIM)) begin
                t = CFG_W'(MAX_DIM - 1);
            end else begin
                t = d - CFG_W'(1);
            end
            return t[DIM_W-1:0];
        end
    endfunction

endpackage

@@ src/mme_ctrl.sv @@
// Controller of the matrix multiply engine: request decode and the row,
// column and inner-index sequencer. Depends on mme_pkg.
module mme_ctrl (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [1:0]                    i_op,
    input  logic [mme_pkg::IDX_W-1:0]     i_index,
    input  logic [mme_pkg::DATA_WIDTH-1:0] i_value,
    input  mme_pkg::t_cfg                 i_cfg,
    input  mme_pkg::t_dp_status           i_status,
    output mme_pkg::t_wr_cmd              o_wr,
    output mme_pkg::t_mac_cmd             o_mac
);
    import mme_pkg::*;

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_RUN   = 2'd1;
    localparam logic [1:0] S_DRAIN = 2'd2;

    logic [1:0]       r_state, n_state;
    logic [DIM_W-1:0] r_i, n_i, r_j, n_j, r_k, n_k;
    logic [DIM_W-1:0] r_lim_r, r_lim_k, r_lim_c;
    logic             r_tr;
    logic             accept;
    logic             in_range;
    logic             k_end, j_end, i_end;

    assign accept   = start && (r_state == S_IDLE);
    assign busy     = (r_state != S_IDLE);
    assign in_range = ({1'b0, i_index} < (IDX_W + 1)'(DEPTH));

    // Decode loads into store writes
    always_comb begin
        o_wr.we_a = accept && (i_op == OP_LOAD_A) && in_range;
        o_wr.we_b = accept && (i_op == OP_LOAD_B) && in_range;
        o_wr.addr = i_index;
        o_wr.data = i_value;
    end

    assign k_end = (r_k == r_lim_k);
    assign j_end = (r_j == r_lim_c);
    assign i_end = (r_i == r_lim_r);

    // Issue one multiply-accumulate step per cycle while running
    always_comb begin
        o_mac.rd            = (r_state == S_RUN);
        o_mac.a_addr        = IDX_W'(IDX_W'(r_i) * IDX_W'(MAX_DIM) + IDX_W'(r_k));
        o_mac.b_addr        = r_tr ? IDX_W'(IDX_W'(r_j) * IDX_W'(MAX_DIM) + IDX_W'(r_k))
                                   : IDX_W'(IDX_W'(r_k) * IDX_W'(MAX_DIM) + IDX_W'(r_j));
        o_mac.tag.first     = (r_k == '0);
        o_mac.tag.last_k    = k_end;
        o_mac.tag.last_elem = k_end && j_end && i_end;
        o_mac.tag.row       = r_i;
        o_mac.tag.col       = r_j;
    end

    // Next state and counters
    always_comb begin
        n_state = r_state;
        n_i     = r_i;
        n_j     = r_j;
        n_k     = r_k;
        unique case (r_state)
            S_IDLE: begin
                if (accept && (i_op == OP_COMPUTE)) begin
                    n_state = S_RUN;
                    n_i     = '0;
                    n_j     = '0;
                    n_k     = '0;
                end
            end
            S_RUN: begin
                if (!k_end) begin
                    n_k = r_k + DIM_W'(1);
                end else begin
                    n_k = '0;
                    if (!j_end) begin
                        n_j = r_j + DIM_W'(1);
                    end else begin
                        n_j = '0;
                        if (!i_end) begin
                            n_i = r_i + DIM_W'(1);
                        end else begin
                            n_state = S_DRAIN;
                        end
                    end
                end
            end
            S_DRAIN: begin
                if (i_status.done) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Hold state; latch clamped dimensions when a compute starts
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
        r_i <= n_i;
        r_j <= n_j;
        r_k <= n_k;
        if (accept && (i_op == OP_COMPUTE)) begin
            r_lim_r <= dim_limit(i_cfg.rows);
            r_lim_k <= dim_limit(i_cfg.inner);
            r_lim_c <= dim_limit(i_cfg.cols);
            r_tr    <= i_cfg.transpose;
        end
    end

endmodule

@@ src/mme_datapath.sv @@
// Datapath of the matrix multiply engine: A and B stores, multiplier,
// accumulator and result register. Depends on mme_pkg.
module mme_datapath (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  mme_pkg::t_wr_cmd           i_wr,
    input  mme_pkg::t_mac_cmd          i_mac,
    output mme_pkg::t_dp_status        o_status,
    output logic                       o_valid,
    output logic [mme_pkg::DIM_W-1:0]  o_row,
    output logic [mme_pkg::DIM_W-1:0]  o_col,
    output logic signed [mme_pkg::RES_W-1:0] o_result_value,
    output logic                       o_last
);
    import mme_pkg::*;

    logic [DATA_WIDTH-1:0] mem_a [DEPTH];
    logic [DATA_WIDTH-1:0] mem_b [DEPTH];

    logic [DATA_WIDTH-1:0]     r_a_rd, r_b_rd;
    logic                      r_s1_vld, r_s2_vld;
    t_tag                      r_s1_tag, r_s2_tag;
    logic signed [PROD_W-1:0]  r_prod;
    logic signed [RES_W-1:0]   r_acc;
    logic signed [RES_W-1:0]   prod_ext;
    logic signed [RES_W-1:0]   sum;
    logic                      r_out_vld;
    logic [DIM_W-1:0]          r_out_row, r_out_col;
    logic signed [RES_W-1:0]   r_out_val;
    logic                      r_out_last;

    // Store writes and registered reads
    always_ff @(posedge i_clk) begin
        if (i_wr.we_a) begin
            mem_a[i_wr.addr] <= i_wr.data;
        end
        if (i_wr.we_b) begin
            mem_b[i_wr.addr] <= i_wr.data;
        end
        r_a_rd <= mem_a[i_mac.a_addr];
        r_b_rd <= mem_b[i_mac.b_addr];
    end

    // Multiply stage
    always_ff @(posedge i_clk) begin
        r_s1_tag <= i_mac.tag;
        r_s2_tag <= r_s1_tag;
        r_prod   <= $signed(r_a_rd) * $signed(r_b_rd);
    end

    // Accumulate: restart on the first inner step
    assign prod_ext = {{(RES_W - PROD_W){r_prod[PROD_W-1]}}, r_prod};
    assign sum      = (r_s2_tag.first ? RES_W'(0) : r_acc) + prod_ext;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld  <= 1'b0;
            r_s2_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_s1_vld  <= i_mac.rd;
            r_s2_vld  <= r_s1_vld;
            r_out_vld <= r_s2_vld && r_s2_tag.last_k;
        end
        if (r_s2_vld) begin
            r_acc <= sum;
        end
        if (r_s2_vld && r_s2_tag.last_k) begin
            r_out_val  <= sum;
            r_out_row  <= r_s2_tag.row;
            r_out_col  <= r_s2_tag.col;
            r_out_last <= r_s2_tag.last_elem;
        end
    end

    assign o_valid         = r_out_vld;
    assign o_row           = r_out_row;
    assign o_col           = r_out_col;
    assign o_result_value  = r_out_val;
    assign o_last          = r_out_last;
    assign o_status.done   = r_out_vld && r_out_last;

endmodule

@@ src/matrix_multiply_engine_core.sv @@
// Top level of the matrix multiply engine: configuration registers and
// the controller/datapath pair. Depends on mme_pkg, mme_ctrl, mme_datapath.
//
// Usage:
//  - Requests enter on start/i_op/i_index/i_value and are taken at a rising
//    edge with start high and busy low. Op load A / load B writes one
//    element of a store at row*8+column; op compute forms A*B, or A*B^T
//    when transpose is set, and emits every result element row-major.
//  - Results appear on o_row/o_col/o_result_value/o_last for one cycle
//    each, flagged by o_valid; o_last marks the final element. The
//    receiver cannot stall the block, so results are never held back.
//  - A load leaves busy low. A compute runs one multiply-accumulate per
//    cycle through a single read port on each store. Each step passes
//    through the store read registers, the product register and the
//    result register, and the results follow in order. Busy stays high
//    while the compute runs and falls after the final result.
//  - Registers (APB, byte address 4*i): rows, inner length, cols, each
//    4 bits and saturated to 1..8 when used, then transpose. Write them
//    only while busy is low.
//  - Reset clears control and sets all dimensions to 8 with no transpose;
//    store contents are undefined until loaded.
module matrix_multiply_engine_core (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic [1:0]                        i_op,
    input  logic [mme_pkg::IDX_W-1:0]         i_index,
    input  logic signed [mme_pkg::DATA_WIDTH-1:0] i_value,
    output logic                              o_valid,
    output logic [mme_pkg::DIM_W-1:0]         o_row,
    output logic [mme_pkg::DIM_W-1:0]         o_col,
    output logic signed [mme_pkg::RES_W-1:0]  o_result_value,
    output logic                              o_last,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [mme_pkg::ADDR_W-1:0]        paddr,
    input  logic [mme_pkg::PDATA_W-1:0]       pwdata,
    output logic [mme_pkg::PDATA_W-1:0]       prdata,
    output logic                              pready
);
    import mme_pkg::*;

    t_cfg       r_cfg;
    logic       cfg_we;
    logic [1:0] reg_sel;
    t_wr_cmd    wr_cmd;
    t_mac_cmd   mac_cmd;
    t_dp_status dp_status;

    assign pready  = 1'b1;
    assign reg_sel = paddr[3:2];
    assign cfg_we  = psel && penable && pwrite;

    // Configuration register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.rows      <= CFG_DIM_RESET;
            r_cfg.inner     <= CFG_DIM_RESET;
            r_cfg.cols      <= CFG_DIM_RESET;
            r_cfg.transpose <= 1'b0;
        end else if (cfg_we) begin
            unique case (reg_sel)
                REG_ROWS:      r_cfg.rows      <= pwdata[CFG_W-1:0];
                REG_INNER:     r_cfg.inner     <= pwdata[CFG_W-1:0];
                REG_COLS:      r_cfg.cols      <= pwdata[CFG_W-1:0];
                REG_TRANSPOSE: r_cfg.transpose <= pwdata[0];
                default: ;
            endcase
        end
    end

    // Register read-back
    always_comb begin
        unique case (reg_sel)
            REG_ROWS:      prdata = PDATA_W'(r_cfg.rows);
            REG_INNER:     prdata = PDATA_W'(r_cfg.inner);
            REG_COLS:      prdata = PDATA_W'(r_cfg.cols);
            REG_TRANSPOSE: prdata = PDATA_W'(r_cfg.transpose);
            default:       prdata = '0;
        endcase
    end

    mme_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_op     (i_op),
        .i_index  (i_index),
        .i_value  (i_value),
        .i_cfg    (r_cfg),
        .i_status (dp_status),
        .o_wr     (wr_cmd),
        .o_mac    (mac_cmd)
    );

    mme_datapath u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_wr           (wr_cmd),
        .i_mac          (mac_cmd),
        .o_status       (dp_status),
        .o_valid        (o_valid),
        .o_row          (o_row),
        .o_col          (o_col),
        .o_result_value (o_result_value),
        .o_last         (o_last)
    );

endmodule

@@ src/mme_checker.sv @@
// Port-level checks for the matrix multiply engine, bound to the top level.
// Depends on mme_pkg and matrix_multiply_engine_core.
module mme_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       start,
    input logic       busy,
    input logic [1:0] i_op,
    input logic       o_valid,
    input logic       o_last,
    input logic       pready
);
    import mme_pkg::*;

    // Results only come out while a compute is in flight
    a_valid_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> busy)
        else $error("result strobe while idle");

    // Final result releases the block
    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_last) |=> !busy)
        else $error("busy after final result");

    // Compute request makes the block busy
    a_compute_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_op == OP_COMPUTE) |=> busy)
        else $error("compute request not started");

    // Loads and unused ops leave the block free
    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_op != OP_COMPUTE) |=> !busy)
        else $error("non-compute request made block busy");

    // Register port never inserts wait states
    a_pready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pready)
        else $error("pready low");

endmodule

bind matrix_multiply_engine_core mme_checker u_mme_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .start   (start),
    .busy    (busy),
    .i_op    (i_op),
    .o_valid (o_valid),
    .o_last  (o_last),
    .pready  (pready)
);
